// ----- src/lru_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_pkg
// Shared widths and the chain and update structs of the LRU frame cells.
// ----------------------------------------------------------------------------
package lru_pkg;

    localparam int FRAMES = 8;
    localparam int IDX_W  = $clog2(FRAMES);
    localparam int RANK_W = $clog2(FRAMES);
    localparam int NUM_W  = IDX_W + 1;
    localparam int PAGE_W = 8;
    localparam int CNT_W  = 32;
    localparam int CFG_W  = 4;
    localparam int OUT_W  = 48;

    localparam logic [NUM_W-1:0] FRAMES_NUM = NUM_W'(FRAMES);
    localparam logic [RANK_W-1:0] RANK_MAX  = RANK_W'(FRAMES - 1);

    // lookup results handed from one cell to the next
    typedef struct packed {
        logic              hit_found;
        logic [IDX_W-1:0]  hit_idx;
        logic [RANK_W-1:0] hit_rank;
        logic              empty_found;
        logic [IDX_W-1:0]  empty_idx;
        logic              best_any;
        logic [RANK_W-1:0] best_rank;
        logic [IDX_W-1:0]  best_idx;
        logic [PAGE_W-1:0] best_page;
    } chain_t;

    // update broadcast to every cell
    typedef struct packed {
        logic              apply;
        logic              miss;
        logic [IDX_W-1:0]  sel;
        logic [RANK_W-1:0] old_rank;
        logic [PAGE_W-1:0] page;
    } upd_t;

endpackage

// ----- src/lru_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_cell
// One frame: resident page, valid mark and recency rank, plus its link of
// the lookup chain (hit, first empty and oldest frame).
// ----------------------------------------------------------------------------
module lru_cell (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [lru_pkg::IDX_W-1:0]        cell_idx,
    input  logic                             active,
    input  logic [lru_pkg::PAGE_W-1:0]       page_in,
    input  lru_pkg::chain_t                  chain_i,
    output lru_pkg::chain_t                  chain_o,
    input  lru_pkg::upd_t                    upd
);

    logic [lru_pkg::PAGE_W-1:0] page_reg;
    logic                       valid_reg, valid_next;
    logic [lru_pkg::RANK_W-1:0] rank_reg, rank_next;

    always_comb begin
        chain_o = chain_i;
        if (active) begin
            if (valid_reg && page_reg == page_in && !chain_i.hit_found) begin
                chain_o.hit_found = 1'b1;
                chain_o.hit_idx   = cell_idx;
                chain_o.hit_rank  = rank_reg;
            end
            if (!valid_reg && !chain_i.empty_found) begin
                chain_o.empty_found = 1'b1;
                chain_o.empty_idx   = cell_idx;
            end
            // strict compare keeps the lowest index on equal ages
            if (!chain_i.best_any || rank_reg > chain_i.best_rank) begin
                chain_o.best_any  = 1'b1;
                chain_o.best_rank = rank_reg;
                chain_o.best_idx  = cell_idx;
                chain_o.best_page = page_reg;
            end
        end
    end

    always_comb begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        if (upd.apply) begin
            if (upd.sel == cell_idx) begin
                rank_next = '0;
                if (upd.miss) begin
                    valid_next = 1'b1;
                end
            end else if (active && valid_reg && (upd.miss || rank_reg < upd.old_rank)
                         && rank_reg != lru_pkg::RANK_MAX) begin
                rank_next = rank_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
        end else begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (upd.apply && upd.miss && upd.sel == cell_idx) begin
            page_reg <= upd.page;
        end
    end

endmodule

// ----- src/lru_page_replacement.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_page_replacement
// LRU frame table built as a row of frame cells: lookup, fill or evict,
// recency update and a saturating fault count.
// ----------------------------------------------------------------------------
//  channel   dir   ports                         payload
//  s_        in    s_tvalid s_tready s_tdata     page_number
//  m_        out   m_tvalid m_tready m_tdata     hit, frame, eviction, faults
//  cfg_      in    cfg_valid cfg_ready cfg_data  frames_in_use
//
//  Each reference is first transferred into the page register; the lookup
//  then ripples through the cell row, followed by the update.
//  A new reference is taken once the previous one has updated the cells.
//  The update waits while the output register holds an untaken result.
//  Reset clears valid marks, ranks, fault count and sets frames_in_use to 8.
// ----------------------------------------------------------------------------
module lru_page_replacement (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lru_pkg::PAGE_W-1:0]    s_tdata,   // [7:0] page_number
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] hit, [3:1] frame_index, [4] evicted_valid, [12:5] evicted_page,
    // [44:13] fault_total, [47:45] zero
    output logic [lru_pkg::OUT_W-1:0]     m_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lru_pkg::CFG_W-1:0]     cfg_data   // [3:0] frames_in_use
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_LOOK = 1'b1;

    logic                        state_reg, state_next;
    logic [lru_pkg::PAGE_W-1:0]  page_reg;
    logic [lru_pkg::CFG_W-1:0]   cfg_reg;
    logic [lru_pkg::CNT_W-1:0]   faults_reg, faults_next;
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [lru_pkg::OUT_W-1:0]   m_tdata_reg, m_tdata_next;
    logic [lru_pkg::NUM_W-1:0]   n_eff;
    logic                        go;
    logic                        ev_valid;
    logic [lru_pkg::IDX_W-1:0]   frame_sel;
    logic [lru_pkg::PAGE_W-1:0]  ev_page;
    lru_pkg::chain_t             chain [lru_pkg::FRAMES+1];
    lru_pkg::chain_t             res;
    lru_pkg::upd_t               upd;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // out-of-range register values clamp to 1..FRAMES
    always_comb begin
        if (cfg_reg == '0) begin
            n_eff = lru_pkg::NUM_W'(1);
        end else if (lru_pkg::CFG_W'(cfg_reg) > lru_pkg::CFG_W'(lru_pkg::FRAMES)) begin
            n_eff = lru_pkg::FRAMES_NUM;
        end else begin
            n_eff = lru_pkg::NUM_W'(cfg_reg);
        end
    end

    assign chain[0] = '0;

    for (genvar g = 0; g < lru_pkg::FRAMES; g++) begin : g_cell
        lru_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_idx (lru_pkg::IDX_W'(g)),
            .active   (lru_pkg::NUM_W'(g) < n_eff),
            .page_in  (page_reg),
            .chain_i  (chain[g]),
            .chain_o  (chain[g+1]),
            .upd      (upd)
        );
    end

    assign res = chain[lru_pkg::FRAMES];
    assign go  = (state_reg == ST_LOOK) && (!m_tvalid_reg || m_tready);

    always_comb begin
        ev_valid  = !res.hit_found && !res.empty_found;
        ev_page   = ev_valid ? res.best_page : '0;
        if (res.hit_found) begin
            frame_sel = res.hit_idx;
        end else if (res.empty_found) begin
            frame_sel = res.empty_idx;
        end else begin
            frame_sel = res.best_idx;
        end

        upd.apply    = go;
        upd.miss     = !res.hit_found;
        upd.sel      = frame_sel;
        upd.old_rank = res.hit_rank;
        upd.page     = page_reg;

        faults_next = faults_reg;
        if (!res.hit_found && faults_reg != '1) begin
            faults_next = faults_reg + 1'b1;
        end
    end

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (go) begin
                    state_next    = ST_IDLE;
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {3'b000, faults_next, ev_page, ev_valid,
                                     frame_sel, res.hit_found};
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            faults_reg   <= '0;
            cfg_reg      <= lru_pkg::CFG_W'(lru_pkg::FRAMES);
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (go) begin
                faults_reg <= faults_next;
            end
            if (cfg_valid && cfg_ready) begin
                cfg_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        if (s_tvalid && s_tready) begin
            page_reg <= s_tdata;
        end
    end

endmodule

// ----- src/lru_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_chk
// Port-level checks for the LRU page replacement block.
// ----------------------------------------------------------------------------
module lru_chk (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [lru_pkg::OUT_W-1:0]     m_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a hit never evicts
    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> !m_tdata[4])
        else $error("eviction reported on hit");

    // evicted page reads zero without an eviction
    a_evict_page: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[4] |-> m_tdata[12:5] == 8'd0)
        else $error("evicted page set without eviction");

    // one reference at a time: input closes right after a transfer
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input open while a lookup is pending");

    // no result right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind lru_page_replacement lru_chk u_lru_chk (.*);
